@@ hdl/dsc_pkg.sv @@
// Shared constants, tables and types for the degree sine and cosine unit.
package dsc_pkg;

    // Default number of fraction bits on the angle and on the results.
    localparam int FRACTION_BITS = 16;

    // Width of the incoming angle word.
    localparam int ANGLE_BITS = 32;

    // Fraction bits of the internal unsigned series arithmetic.
    localparam int WORK_BITS = 30;

    // Pi in Q60 and pi/180 in Q38, both truncated.
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [32:0] DEG2RAD_Q38 = 33'((PI_Q60 / 64'd180) >> 22);

    // Divisors of the nested series terms, innermost first.
    localparam int SIN_TERMS = 5;
    localparam int COS_TERMS = 6;
    localparam int unsigned SIN_DIV [SIN_TERMS] = '{110, 72, 42, 20, 6};
    localparam int unsigned COS_DIV [COS_TERMS] = '{132, 90, 56, 30, 12, 2};

    // Quadrant codes of the folded angle.
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Where the reduced angle came from: its quadrant and whether it was mirrored.
    typedef struct packed {
        logic [1:0] quad;
        logic       swap;
    } t_dir;

endpackage

@@ hdl/dsc_if.sv @@
// Valid/ready channel interfaces for the angle input and the sine/cosine output.
interface dsc_angle_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [dsc_pkg::ANGLE_BITS-1:0]  angle_deg;

    modport source (output valid, output angle_deg, input ready);
    modport sink   (input valid, input angle_deg, output ready);
endinterface

interface dsc_trig_if #(
    parameter int FRACTION_BITS = dsc_pkg::FRACTION_BITS
);
    logic                            valid;
    logic                            ready;
    logic signed [FRACTION_BITS+1:0] sine;
    logic signed [FRACTION_BITS+1:0] cosine;

    modport source (output valid, output sine, output cosine, input ready);
    modport sink   (input valid, input sine, input cosine, output ready);
endinterface

@@ hdl/dsc_fold.sv @@
// Angle folding front end: magnitude, modulo one turn, octant reduction and radians.
module dsc_fold #(
    parameter int FRACTION_BITS = dsc_pkg::FRACTION_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_adv,
    input  logic                                  i_vld,
    input  logic signed [dsc_pkg::ANGLE_BITS-1:0] i_angle,
    output logic                                  o_vld,
    output logic [dsc_pkg::WORK_BITS-1:0]         o_r,
    output logic [dsc_pkg::WORK_BITS-1:0]         o_r2,
    output dsc_pkg::t_dir                         o_dir
);

    localparam int F      = FRACTION_BITS;
    localparam int AW     = dsc_pkg::ANGLE_BITS;
    localparam int W      = dsc_pkg::WORK_BITS;
    localparam int NW     = AW - F;
    localparam int RW     = 10;
    localparam int IW     = 9;
    localparam int DW     = 7;
    localparam int XW     = F + 6;
    localparam int STAGES = 8;

    localparam int TURN    = 360;
    localparam int QUARTER = 90;
    localparam int EIGHTH  = 45;

    localparam logic [NW-1:0]  RECIP      = NW'((64'd1 << NW) / 64'd360);
    localparam logic [F+6:0]   EIGHTH_FX  = (F + 7)'(EIGHTH) << F;
    localparam logic [F+6:0]   QUARTER_FX = (F + 7)'(QUARTER) << F;

    logic [STAGES-1:0] r_vld;

    // Stage 1: magnitude.
    logic [AW-1:0]   r1_m;
    logic            r1_neg;
    logic [AW-1:0]   n1_m;

    // Stage 2: integer degrees split off, quotient estimate by 360.
    logic [NW-1:0]   r2_n;
    logic [NW-1:0]   r2_qe;
    logic [F-1:0]    r2_frac;
    logic            r2_neg;
    logic [2*NW-1:0] w_qprod;

    // Stage 3: remainder before correction.
    logic [RW-1:0]   r3_r0;
    logic [F-1:0]    r3_frac;
    logic            r3_neg;
    logic [NW+8:0]   w_qm;
    logic [NW+8:0]   w_r0;

    // Stage 4: folded angle in 0 to 360 degrees.
    logic [IW-1:0]   r4_ideg;
    logic [F-1:0]    r4_frac;
    logic [RW-1:0]   w_rem_full;
    logic [IW-1:0]   w_rem;
    logic [IW-1:0]   n4_ideg;
    logic [F-1:0]    n4_frac;

    // Stage 5: quadrant and degrees within it.
    logic [1:0]      r5_quad;
    logic [DW-1:0]   r5_dint;
    logic [F-1:0]    r5_frac;
    logic [1:0]      n5_quad;
    logic [DW-1:0]   n5_dint;

    // Stage 6: reduced angle of at most 45 degrees.
    logic [XW-1:0]   r6_x;
    dsc_pkg::t_dir   r6_dir;
    logic [F+6:0]    w_d;
    logic            w_swap;
    logic [F+6:0]    w_x_full;

    // Stage 7: radians in Q30.
    logic [W-1:0]    r7_r;
    dsc_pkg::t_dir   r7_dir;
    logic [XW+32:0]  w_rprod;

    // Stage 8: square of the radians.
    logic [W-1:0]    r8_r;
    logic [W-1:0]    r8_r2;
    dsc_pkg::t_dir   r8_dir;
    logic [2*W-1:0]  w_sq;

    assign n1_m     = i_angle[AW-1] ? (~i_angle + AW'(1)) : i_angle;

    assign w_qprod  = (2 * NW)'(r1_m[AW-1:F]) * (2 * NW)'(RECIP);

    assign w_qm     = (NW + 9)'(r2_qe) * (NW + 9)'(TURN);
    assign w_r0     = (NW + 9)'(r2_n) - w_qm;

    assign w_rem_full = (r3_r0 >= RW'(TURN)) ? (r3_r0 - RW'(TURN)) : r3_r0;
    assign w_rem      = w_rem_full[IW-1:0];

    // A negative angle is a turn minus the remainder of its magnitude.
    always_comb begin
        n4_ideg = w_rem;
        n4_frac = r3_frac;
        if (r3_neg) begin
            if (r3_frac == '0) begin
                n4_ideg = IW'(TURN) - w_rem;
            end else begin
                n4_ideg = IW'(TURN - 1) - w_rem;
                n4_frac = F'(0) - r3_frac;
            end
        end
    end

    // A full turn wraps back to quadrant zero.
    always_comb begin
        priority if (r4_ideg >= IW'(TURN)) begin
            n5_quad = dsc_pkg::QUAD_0;
            n5_dint = '0;
        end else if (r4_ideg >= IW'(3 * QUARTER)) begin
            n5_quad = dsc_pkg::QUAD_3;
            n5_dint = DW'(r4_ideg - IW'(3 * QUARTER));
        end else if (r4_ideg >= IW'(2 * QUARTER)) begin
            n5_quad = dsc_pkg::QUAD_2;
            n5_dint = DW'(r4_ideg - IW'(2 * QUARTER));
        end else if (r4_ideg >= IW'(QUARTER)) begin
            n5_quad = dsc_pkg::QUAD_1;
            n5_dint = DW'(r4_ideg - IW'(QUARTER));
        end else begin
            n5_quad = dsc_pkg::QUAD_0;
            n5_dint = DW'(r4_ideg);
        end
    end

    assign w_d      = {r5_dint, r5_frac};
    assign w_swap   = w_d > EIGHTH_FX;
    assign w_x_full = w_swap ? (QUARTER_FX - w_d) : w_d;

    assign w_rprod  = (XW + 33)'(r6_x) * (XW + 33)'(dsc_pkg::DEG2RAD_Q38);

    assign w_sq     = (2 * W)'(r7_r) * (2 * W)'(r7_r);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[STAGES-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_m        <= n1_m;
            r1_neg      <= i_angle[AW-1];

            r2_n        <= r1_m[AW-1:F];
            r2_qe       <= w_qprod[2*NW-1:NW];
            r2_frac     <= r1_m[F-1:0];
            r2_neg      <= r1_neg;

            r3_r0       <= w_r0[RW-1:0];
            r3_frac     <= r2_frac;
            r3_neg      <= r2_neg;

            r4_ideg     <= n4_ideg;
            r4_frac     <= n4_frac;

            r5_quad     <= n5_quad;
            r5_dint     <= n5_dint;
            r5_frac     <= r4_frac;

            r6_x        <= w_x_full[XW-1:0];
            r6_dir.quad <= r5_quad;
            r6_dir.swap <= w_swap;

            r7_r        <= w_rprod[F+8 +: W];
            r7_dir      <= r6_dir;

            r8_r        <= r7_r;
            r8_r2       <= w_sq[2*W-1:W];
            r8_dir      <= r7_dir;
        end
    end

    assign o_vld = r_vld[STAGES-1];
    assign o_r   = r8_r;
    assign o_r2  = r8_r2;
    assign o_dir = r8_dir;

endmodule

@@ hdl/dsc_series_step.sv @@
// One nested series term t' = 1 - (r2 * t) / k, in three register stages.
module dsc_series_step #(
    parameter int unsigned DIVISOR = 2,
    parameter int          SIDE_W  = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_vld,
    input  logic [dsc_pkg::WORK_BITS-1:0] i_r2,
    input  logic [dsc_pkg::WORK_BITS:0]   i_t,
    input  logic [SIDE_W-1:0]             i_side,
    output logic                          o_vld,
    output logic [dsc_pkg::WORK_BITS-1:0] o_r2,
    output logic [dsc_pkg::WORK_BITS:0]   o_t,
    output logic [SIDE_W-1:0]             o_side
);

    localparam int W = dsc_pkg::WORK_BITS;

    localparam logic [W:0]   ONE   = (W + 1)'(1) << W;
    localparam logic [W-1:0] RECIP = W'((64'd1 << W) / 64'(DIVISOR));
    localparam logic [W-1:0] DIV_W = W'(DIVISOR);

    logic [2:0]        r_vld;

    logic [W-1:0]      ra_p;
    logic [W-1:0]      ra_r2;
    logic [SIDE_W-1:0] ra_side;
    logic [2*W:0]      w_prod;

    logic [W-1:0]      rb_p;
    logic [W-1:0]      rb_qe;
    logic [W-1:0]      rb_r2;
    logic [SIDE_W-1:0] rb_side;
    logic [2*W-1:0]    w_qprod;

    logic [W:0]        rc_t;
    logic [W-1:0]      rc_r2;
    logic [SIDE_W-1:0] rc_side;
    logic [W-1:0]      w_qk;
    logic [W-1:0]      w_rem;
    logic              w_ge;
    logic [W:0]        n_t;

    assign w_prod  = (2 * W + 1)'(i_r2) * (2 * W + 1)'(i_t);

    // The reciprocal estimate is low by at most one; the remainder check fixes it.
    assign w_qprod = (2 * W)'(ra_p) * (2 * W)'(RECIP);

    assign w_qk    = W'(rb_qe * DIV_W);
    assign w_rem   = rb_p - w_qk;
    assign w_ge    = w_rem >= DIV_W;
    assign n_t     = ONE - {1'b0, rb_qe} - (W + 1)'(w_ge);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            ra_p    <= w_prod[2*W-1:W];
            ra_r2   <= i_r2;
            ra_side <= i_side;

            rb_p    <= ra_p;
            rb_qe   <= w_qprod[2*W-1:W];
            rb_r2   <= ra_r2;
            rb_side <= ra_side;

            rc_t    <= n_t;
            rc_r2   <= rb_r2;
            rc_side <= rb_side;
        end
    end

    assign o_vld  = r_vld[2];
    assign o_r2   = rc_r2;
    assign o_t    = rc_t;
    assign o_side = rc_side;

endmodule

@@ hdl/degree_sine_cosine.sv @@
// Top level of the degree sine and cosine unit: folding front end, two series lanes, output.
//
//  Channel  Side  Payload                              Word format
//  -------  ----  -----------------------------------  ---------------------------------
//  i_angle  in    angle_deg                            signed 32 bits, degrees, Q.F
//  o_trig   out   sine, cosine                         signed F+2 bits each, Q.F, +/-1
//
// The unit takes one word on every clock while no result word is held and hands back
// one result word for each, through the folding and radian conversion stages, the
// six-term cosine lane (the sine lane matches it with its final product and delay
// stages), the rounding register and the output register.
// Reset clears only the valid bits of every stage and of the output register.
// When a finished word waits on o_trig and the sink is not ready, every stage holds
// and i_angle drops ready; nothing in flight is lost or repeated.
module degree_sine_cosine #(
    parameter int FRACTION_BITS = dsc_pkg::FRACTION_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dsc_angle_if.sink         i_angle,
    dsc_trig_if.source        o_trig
);

    localparam int F        = FRACTION_BITS;
    localparam int W        = dsc_pkg::WORK_BITS;
    localparam int OB       = F + 2;
    localparam int SIN_N    = dsc_pkg::SIN_TERMS;
    localparam int COS_N    = dsc_pkg::COS_TERMS;
    localparam int DIRW     = $bits(dsc_pkg::t_dir);
    // The sine lane has fewer terms; its final product and some delay fill the gap.
    localparam int SIN_TAIL = 3 * (COS_N - SIN_N);
    localparam int SH       = W - F;

    localparam logic [W:0]   ONE  = (W + 1)'(1) << W;
    localparam logic [W:0]   HALF = (W + 1)'(1) << (SH - 1);
    localparam logic [F:0]   LIM  = (F + 1)'(1) << F;

    // Global advance: the whole pipeline moves unless a result word is held.
    logic              w_adv;

    logic              w_fold_vld;
    logic [W-1:0]      w_fold_r;
    logic [W-1:0]      w_fold_r2;
    dsc_pkg::t_dir     w_fold_dir;

    // Sine lane: r travels alongside as side data for the final product.
    logic              w_sin_vld  [SIN_N+1];
    logic [W-1:0]      w_sin_r2   [SIN_N];
    logic [W:0]        w_sin_t    [SIN_N+1];
    logic [W-1:0]      w_sin_side [SIN_N+1];

    // Cosine lane: quadrant and mirror flag travel alongside.
    logic              w_cos_vld  [COS_N+1];
    logic [W-1:0]      w_cos_r2   [COS_N];
    logic [W:0]        w_cos_t    [COS_N+1];
    logic [DIRW-1:0]   w_cos_side [COS_N+1];
    dsc_pkg::t_dir     w_end_dir;

    // Sine tail: product r * t, then delay to line up with the cosine lane.
    logic [2*W:0]          w_s_prod;
    logic [W:0]            r_sin_pipe [SIN_TAIL];
    logic [SIN_TAIL-1:0]   r_sin_pipe_vld;
    logic                  w_join_vld;

    // Rounding stage.
    logic [W:0]        w_s_sum;
    logic [W:0]        w_c_sum;
    logic [F:0]        w_s_rnd;
    logic [F:0]        w_c_rnd;
    logic [F:0]        w_s_sat;
    logic [F:0]        w_c_sat;
    logic              r_rnd_vld;
    logic [F:0]        r_rnd_s;
    logic [F:0]        r_rnd_c;
    logic [1:0]        r_rnd_quad;

    // Output register and quadrant mapping.
    logic [OB-1:0]     w_s_ext;
    logic [OB-1:0]     w_c_ext;
    logic [OB-1:0]     n_sine;
    logic [OB-1:0]     n_cosine;
    logic              r_out_vld;
    logic [OB-1:0]     r_sine;
    logic [OB-1:0]     r_cosine;

    assign w_adv         = !r_out_vld || o_trig.ready;
    assign i_angle.ready = w_adv && i_rst_n;

    dsc_fold #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (i_angle.valid),
        .i_angle (i_angle.angle_deg),
        .o_vld   (w_fold_vld),
        .o_r     (w_fold_r),
        .o_r2    (w_fold_r2),
        .o_dir   (w_fold_dir)
    );

    assign w_sin_vld[0]  = w_fold_vld;
    assign w_sin_r2[0]   = w_fold_r2;
    assign w_sin_t[0]    = ONE;
    assign w_sin_side[0] = w_fold_r;

    assign w_cos_vld[0]  = w_fold_vld;
    assign w_cos_r2[0]   = w_fold_r2;
    assign w_cos_t[0]    = ONE;
    assign w_cos_side[0] = w_fold_dir;

    // Each series term is its own three-stage step; the innermost divisor comes first.
    for (genvar gi = 0; gi < SIN_N; gi++) begin : g_sin
        if (gi < SIN_N - 1) begin : g_mid
            dsc_series_step #(
                .DIVISOR (dsc_pkg::SIN_DIV[gi]),
                .SIDE_W  (W)
            ) u_step (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (w_adv),
                .i_vld   (w_sin_vld[gi]),
                .i_r2    (w_sin_r2[gi]),
                .i_t     (w_sin_t[gi]),
                .i_side  (w_sin_side[gi]),
                .o_vld   (w_sin_vld[gi+1]),
                .o_r2    (w_sin_r2[gi+1]),
                .o_t     (w_sin_t[gi+1]),
                .o_side  (w_sin_side[gi+1])
            );
        end else begin : g_last
            dsc_series_step #(
                .DIVISOR (dsc_pkg::SIN_DIV[gi]),
                .SIDE_W  (W)
            ) u_step (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (w_adv),
                .i_vld   (w_sin_vld[gi]),
                .i_r2    (w_sin_r2[gi]),
                .i_t     (w_sin_t[gi]),
                .i_side  (w_sin_side[gi]),
                .o_vld   (w_sin_vld[gi+1]),
                .o_r2    (),
                .o_t     (w_sin_t[gi+1]),
                .o_side  (w_sin_side[gi+1])
            );
        end
    end

    for (genvar gi = 0; gi < COS_N; gi++) begin : g_cos
        if (gi < COS_N - 1) begin : g_mid
            dsc_series_step #(
                .DIVISOR (dsc_pkg::COS_DIV[gi]),
                .SIDE_W  (DIRW)
            ) u_step (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (w_adv),
                .i_vld   (w_cos_vld[gi]),
                .i_r2    (w_cos_r2[gi]),
                .i_t     (w_cos_t[gi]),
                .i_side  (w_cos_side[gi]),
                .o_vld   (w_cos_vld[gi+1]),
                .o_r2    (w_cos_r2[gi+1]),
                .o_t     (w_cos_t[gi+1]),
                .o_side  (w_cos_side[gi+1])
            );
        end else begin : g_last
            dsc_series_step #(
                .DIVISOR (dsc_pkg::COS_DIV[gi]),
                .SIDE_W  (DIRW)
            ) u_step (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (w_adv),
                .i_vld   (w_cos_vld[gi]),
                .i_r2    (w_cos_r2[gi]),
                .i_t     (w_cos_t[gi]),
                .i_side  (w_cos_side[gi]),
                .o_vld   (w_cos_vld[gi+1]),
                .o_r2    (),
                .o_t     (w_cos_t[gi+1]),
                .o_side  (w_cos_side[gi+1])
            );
        end
    end

    assign w_end_dir = w_cos_side[COS_N];

    // Sine of the reduced angle is r times the nested series value.
    assign w_s_prod = (2 * W + 1)'(w_sin_side[SIN_N]) * (2 * W + 1)'(w_sin_t[SIN_N]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sin_pipe_vld <= '0;
        end else if (w_adv) begin
            r_sin_pipe_vld <= {r_sin_pipe_vld[SIN_TAIL-2:0], w_sin_vld[SIN_N]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sin_pipe[0] <= w_s_prod[2*W:W];
            for (int k = 1; k < SIN_TAIL; k++) begin
                r_sin_pipe[k] <= r_sin_pipe[k-1];
            end
        end
    end

    assign w_join_vld = r_sin_pipe_vld[SIN_TAIL-1] & w_cos_vld[COS_N];

    // Round half up to F fraction bits and limit to one.
    assign w_s_sum = r_sin_pipe[SIN_TAIL-1] + HALF;
    assign w_c_sum = w_cos_t[COS_N] + HALF;
    assign w_s_rnd = w_s_sum[W:SH];
    assign w_c_rnd = w_c_sum[W:SH];
    assign w_s_sat = (w_s_rnd > LIM) ? LIM : w_s_rnd;
    assign w_c_sat = (w_c_rnd > LIM) ? LIM : w_c_rnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd_vld <= 1'b0;
        end else if (w_adv) begin
            r_rnd_vld <= w_join_vld;
        end
    end

    // A mirrored octant swaps the roles of sine and cosine.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rnd_s    <= w_end_dir.swap ? w_c_sat : w_s_sat;
            r_rnd_c    <= w_end_dir.swap ? w_s_sat : w_c_sat;
            r_rnd_quad <= w_end_dir.quad;
        end
    end

    assign w_s_ext = OB'(r_rnd_s);
    assign w_c_ext = OB'(r_rnd_c);

    // Each quadrant rotates the first-quadrant pair by a further quarter turn.
    always_comb begin
        unique case (r_rnd_quad)
            dsc_pkg::QUAD_0: begin
                n_sine   = w_s_ext;
                n_cosine = w_c_ext;
            end
            dsc_pkg::QUAD_1: begin
                n_sine   = w_c_ext;
                n_cosine = OB'(0) - w_s_ext;
            end
            dsc_pkg::QUAD_2: begin
                n_sine   = OB'(0) - w_s_ext;
                n_cosine = OB'(0) - w_c_ext;
            end
            dsc_pkg::QUAD_3: begin
                n_sine   = OB'(0) - w_c_ext;
                n_cosine = w_s_ext;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_rnd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sine   <= n_sine;
            r_cosine <= n_cosine;
        end
    end

    assign o_trig.valid  = r_out_vld;
    assign o_trig.sine   = r_sine;
    assign o_trig.cosine = r_cosine;

endmodule

@@ hdl/dsc_checker.sv @@
// Port-level checks for the degree sine and cosine unit, bound to its top level.
module dsc_checker #(
    parameter int FRACTION_BITS = dsc_pkg::FRACTION_BITS
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic signed [FRACTION_BITS+1:0] i_sine,
    input logic signed [FRACTION_BITS+1:0] i_cosine
);

    localparam int OB = FRACTION_BITS + 2;

    localparam logic signed [OB-1:0] POS_ONE = OB'(1) << FRACTION_BITS;
    localparam logic signed [OB-1:0] NEG_ONE = OB'(0) - POS_ONE;
    // Sum of magnitudes never falls below one; leave room for rounding.
    localparam logic [OB:0] MIN_SUM =
        ((OB + 1)'(1) << FRACTION_BITS) - ((OB + 1)'(1) << (FRACTION_BITS - 4));

    logic [OB-1:0] w_abs_s;
    logic [OB-1:0] w_abs_c;
    logic [OB:0]   w_sum;

    assign w_abs_s = i_sine[OB-1]   ? (OB'(0) - i_sine)   : i_sine;
    assign w_abs_c = i_cosine[OB-1] ? (OB'(0) - i_cosine) : i_cosine;
    assign w_sum   = (OB + 1)'(w_abs_s) + (OB + 1)'(w_abs_c);

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_sine <= POS_ONE && i_sine >= NEG_ONE &&
                         i_cosine <= POS_ONE && i_cosine >= NEG_ONE))
        else $error("sine or cosine beyond plus or minus one");

    a_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (w_sum >= MIN_SUM))
        else $error("sine and cosine magnitudes too small for a unit vector");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_sine) && $stable(i_cosine)))
        else $error("result word changed or vanished while stalled");

    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input refused although the output can move");

endmodule

bind degree_sine_cosine dsc_checker #(
    .FRACTION_BITS (FRACTION_BITS)
) u_dsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_angle.ready),
    .i_out_valid (o_trig.valid),
    .i_out_ready (o_trig.ready),
    .i_sine      (o_trig.sine),
    .i_cosine    (o_trig.cosine)
);

@@ test/degree_sine_cosine_test.sv @@
// Self-checking testbench for the degree sine and cosine unit.
`timescale 1ns / 100ps

module degree_sine_cosine_test;

    // Fraction bits of the angle and of the results, and the width of one result field.
    localparam int FB    = dsc_pkg::FRACTION_BITS;
    localparam int OUT_W = FB + 2;

    // Angles in the fixed-point degree format that the folding works with.
    localparam logic [63:0] FULL_TURN = 64'd360 << FB;
    localparam logic [63:0] QUARTER   = 64'd90 << FB;
    localparam logic [63:0] EIGHTH    = 64'd45 << FB;

    // The series runs on unsigned Q30 words; pi/180 is carried in Q38.
    localparam int          Q_BITS   = 30;
    localparam logic [63:0] Q_ONE    = 64'd1 << Q_BITS;
    localparam logic [63:0] RAD_Q38  = (64'h3243F6A8885A308D / 64'd180) >> 22;
    localparam logic [63:0] UNITY    = 64'd1 << FB;

    // The tail leaves a good margin after the unit answers the last word.
    localparam int TAIL_CYCLES = 60;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_WORDS = 1400;

    // Receiver stalling patterns.
    typedef enum logic [1:0] {
        RX_FLOW,
        RX_COIN,
        RX_SPARSE,
        RX_HICCUP
    } t_rx_mode;

    // One expected result word, tagged with the angle that caused it.
    typedef struct {
        logic signed [31:0] angle;
        logic [OUT_W-1:0]   sine;
        logic [OUT_W-1:0]   cosine;
    } t_trig_word;

    // Holds the sine and cosine that every accepted angle should produce, oldest first,
    // and compares the words that come out against them.
    class t_trig_ledger;
        t_trig_word awaited_trig[$];
        int         faults;
        int         checked;

        function new();
            faults  = 0;
            checked = 0;
        endfunction

        task report(input string what);
            $display("MISMATCH at %0t: %s", $time, what);
            faults++;
        endtask

        // Truncating Q30 product.
        function logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
            return (a * b) >> Q_BITS;
        endfunction

        // Rounds a Q30 value half up to the output fraction and limits it to one.
        function logic [63:0] round_to_out(input logic [63:0] v);
            logic [63:0] r;
            r = (v + (64'd1 << (Q_BITS - FB - 1))) >> (Q_BITS - FB);
            return (r > UNITY) ? UNITY : r;
        endfunction

        // Sine and cosine of a reduced angle between 0 and 45 degrees, by the nested
        // truncated series: sine to the eleventh power, cosine to the twelfth.
        function void octant_series(input logic [63:0] x,
                                    output logic [63:0] s, output logic [63:0] c);
            logic [63:0] rad;
            logic [63:0] rad_sq;
            logic [63:0] t;
            rad    = (x * RAD_Q38) >> (FB + 8);
            rad_sq = q30_mul(rad, rad);
            t = Q_ONE;
            t = Q_ONE - q30_mul(rad_sq, t) / 64'd110;
            t = Q_ONE - q30_mul(rad_sq, t) / 64'd72;
            t = Q_ONE - q30_mul(rad_sq, t) / 64'd42;
            t = Q_ONE - q30_mul(rad_sq, t) / 64'd20;
            t = Q_ONE - q30_mul(rad_sq, t) / 64'd6;
            s = round_to_out(q30_mul(rad, t));
            t = Q_ONE;
            t = Q_ONE - q30_mul(rad_sq, t) / 64'd132;
            t = Q_ONE - q30_mul(rad_sq, t) / 64'd90;
            t = Q_ONE - q30_mul(rad_sq, t) / 64'd56;
            t = Q_ONE - q30_mul(rad_sq, t) / 64'd30;
            t = Q_ONE - q30_mul(rad_sq, t) / 64'd12;
            t = Q_ONE - q30_mul(rad_sq, t) / 64'd2;
            c = round_to_out(t);
        endfunction

        function t_trig_word sine_cosine_of(input logic signed [31:0] angle);
            t_trig_word       w;
            logic [63:0]      mag;
            logic [63:0]      turn;
            logic [63:0]      rem;
            logic [1:0]       quad;
            logic [63:0]      s_base;
            logic [63:0]      c_base;
            logic [OUT_W-1:0] s;
            logic [OUT_W-1:0] c;
            // The magnitude is taken in 64 bits, so the most negative angle is exact.
            mag  = angle[31] ? (64'h1_0000_0000 - {32'd0, angle}) : {32'd0, angle};
            turn = mag % FULL_TURN;
            // Negative angles count back from a full turn; an exact negative multiple
            // lands on 360 degrees, which the quadrant split treats as zero.
            if (angle[31]) begin
                turn = FULL_TURN - turn;
            end
            quad = 2'((turn / QUARTER) % 64'd4);
            rem  = turn % QUARTER;
            if (rem > EIGHTH) begin
                octant_series(QUARTER - rem, c_base, s_base);
            end else begin
                octant_series(rem, s_base, c_base);
            end
            s = s_base[OUT_W-1:0];
            c = c_base[OUT_W-1:0];
            w.angle = angle;
            unique case (quad)
                dsc_pkg::QUAD_0: begin
                    w.sine = s;
                    w.cosine = c;
                end
                dsc_pkg::QUAD_1: begin
                    w.sine = c;
                    w.cosine = -s;
                end
                dsc_pkg::QUAD_2: begin
                    w.sine = -s;
                    w.cosine = -c;
                end
                default: begin
                    w.sine = -c;
                    w.cosine = s;
                end
            endcase
            return w;
        endfunction

        function void note_angle(input logic signed [31:0] angle);
            awaited_trig.push_back(sine_cosine_of(angle));
        endfunction

        task check_trig(input logic [OUT_W-1:0] sine, input logic [OUT_W-1:0] cosine);
            t_trig_word w;
            checked++;
            if (awaited_trig.size() == 0) begin
                report($sformatf("result sine %0h cosine %0h with no angle outstanding",
                                 sine, cosine));
            end else begin
                w = awaited_trig.pop_front();
                if (sine !== w.sine) begin
                    report($sformatf("angle %0h: sine %0h, expected %0h",
                                     w.angle, sine, w.sine));
                end
                if (cosine !== w.cosine) begin
                    report($sformatf("angle %0h: cosine %0h, expected %0h",
                                     w.angle, cosine, w.cosine));
                end
            end
        endtask

        function int pending();
            return awaited_trig.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   cycle_count;

    dsc_angle_if                      angle_ch ();
    dsc_trig_if #(.FRACTION_BITS(FB)) trig_ch ();

    degree_sine_cosine #(
        .FRACTION_BITS (FB)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_angle (angle_ch),
        .o_trig  (trig_ch)
    );

    t_trig_ledger ledger = new();

    // 20 ns clock.
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost word ends the run here.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offers one angle and holds it until the unit takes it. Valid is left high, so
    // back-to-back words go in without a bubble; the caller lowers it for a gap.
    task automatic send_angle(input logic signed [31:0] angle);
        angle_ch.valid     <= 1'b1;
        angle_ch.angle_deg <= angle;
        do begin
            @(posedge i_clk);
        end while (!(angle_ch.valid && angle_ch.ready));
        ledger.note_angle(angle);
    endtask

    // A gap on the input; the angle bus carries rubbish meanwhile, which must be ignored.
    task automatic idle_input(input int cycles);
        angle_ch.valid     <= 1'b0;
        angle_ch.angle_deg <= $urandom;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Picks an angle from one of several families: anything at all, a couple of turns
    // either side of zero, close to an octant boundary, exact multiples of a turn, and
    // the extremes of the word.
    function automatic logic signed [31:0] random_angle();
        int k;
        unique case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: return int'($urandom_range(0, 1440 * 65536)) - 720 * 65536;
            3: begin
                k = int'($urandom_range(0, 80)) - 40;
                return k * 45 * 65536 + int'($urandom_range(0, 8)) - 4;
            end
            4: begin
                k = int'($urandom_range(0, 180)) - 90;
                return k * 360 * 65536;
            end
            default: begin
                if ($urandom_range(0, 1) == 0) begin
                    return 32'h7FFF_FF00 + $urandom_range(0, 255);
                end
                return 32'h8000_0000 + $urandom_range(0, 255);
            end
        endcase
    endfunction

    // Stimulus: reset, a short directed list, then random words in bursts.
    initial begin
        logic signed [31:0] directed[$];
        int                 burst_left;
        int                 gap;

        i_rst_n            <= 1'b0;
        angle_ch.valid     <= 1'b0;
        angle_ch.angle_deg <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Quadrant and octant corners, the word extremes, the smallest steps either
        // side of zero, and exact negative turns, which must fold to 360 degrees.
        directed = '{0, 45 * 65536, 90 * 65536, 135 * 65536, 180 * 65536,
                     225 * 65536, 270 * 65536, 315 * 65536, 360 * 65536,
                     -360 * 65536, -720 * 65536, -90 * 65536, 1, -1,
                     45 * 65536 - 1, 45 * 65536 + 1, 90 * 65536 - 1,
                     30 * 65536, 60 * 65536, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA};
        foreach (directed[i]) begin
            send_angle(directed[i]);
        end

        burst_left = 0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                // A third of the bursts follow straight on, so there are long
                // stretches with no gap at all.
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                if (gap > 0) begin
                    idle_input(gap);
                end
            end
            burst_left--;
            send_angle(random_angle());
        end
        angle_ch.valid <= 1'b0;

        // Drain, then give the pipeline time to show any stray word.
        while (ledger.pending() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (ledger.faults == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Receiver: samples finished words and moves ready through random patterns. Twice
    // in the run it holds off for a long stretch so that the pipeline fills up and the
    // input side has to stall.
    initial begin
        t_rx_mode mode;
        int       run_left;
        int       hold_left;
        int       holds_done;

        trig_ch.ready <= 1'b0;
        mode       = RX_FLOW;
        run_left   = 0;
        hold_left  = 0;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (trig_ch.valid && trig_ch.ready) begin
                ledger.check_trig(trig_ch.sine, trig_ch.cosine);
            end
            if (hold_left == 0 && holds_done < 2 &&
                ledger.checked >= (holds_done + 1) * 500) begin
                hold_left = 400;
                holds_done++;
            end
            if (run_left == 0) begin
                mode     = t_rx_mode'($urandom_range(0, 3));
                run_left = $urandom_range(1, 60);
            end
            run_left--;
            if (!i_rst_n) begin
                trig_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                trig_ch.ready <= 1'b0;
            end else begin
                unique case (mode)
                    RX_FLOW:   trig_ch.ready <= 1'b1;
                    RX_COIN:   trig_ch.ready <= $urandom_range(0, 1);
                    RX_SPARSE: trig_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:   trig_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

endmodule

@@ filelist.f @@
hdl/dsc_pkg.sv
hdl/dsc_if.sv
hdl/dsc_fold.sv
hdl/dsc_series_step.sv
hdl/degree_sine_cosine.sv
hdl/dsc_checker.sv
test/degree_sine_cosine_test.sv
